>>> hw/rtl/gds_pkg.sv
// Shared types, constants and month-length function for the Gregorian date day stepper.
package gds_pkg;

	localparam logic [13:0] YEAR_MAX    = 14'd9999;
	localparam logic [3:0]  MONTH_JAN   = 4'd0;
	localparam logic [3:0]  MONTH_FEB   = 4'd1;
	localparam logic [3:0]  MONTH_APR   = 4'd3;
	localparam logic [3:0]  MONTH_JUN   = 4'd5;
	localparam logic [3:0]  MONTH_SEP   = 4'd8;
	localparam logic [3:0]  MONTH_NOV   = 4'd10;
	localparam logic [3:0]  LAST_MONTH  = 4'd11;
	localparam logic [4:0]  DAYS_SHORT  = 5'd30;
	localparam logic [4:0]  DAYS_LONG   = 5'd31;
	localparam logic [4:0]  DAYS_FEB    = 5'd28;
	localparam logic [4:0]  DAYS_FEB_LP = 5'd29;
	localparam logic [4:0]  FIRST_DAY   = 5'd1;
	localparam logic [12:0] CENT_RECIP  = 13'd5243;
	localparam int          CENT_SHIFT  = 19;
	localparam logic [6:0]  CENTURY     = 7'd100;
	localparam logic [6:0]  LAST_REM    = 7'd99;

	typedef struct packed {
		logic        operation;
		logic [13:0] start_year;
		logic [3:0]  start_month;
		logic [4:0]  start_day;
		logic [15:0] day_count;
	} gds_req_t;

	typedef struct packed {
		logic [13:0] result_year;
		logic [3:0]  result_month;
		logic [4:0]  result_day;
		logic        range_error;
	} gds_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_REM,
		ST_CLAMP,
		ST_STEP,
		ST_DONE
	} gds_state_t;

	typedef struct packed {
		logic load;
		logic div;
		logic rem;
		logic clamp;
		logic step;
		logic emit;
	} gds_cmd_t;

	typedef struct packed {
		logic year_bad;
		logic cnt_zero;
		logic bound;
	} gds_status_t;

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		if (m == MONTH_FEB) begin
			len = leap ? DAYS_FEB_LP : DAYS_FEB;
		end else if (m inside {MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV}) begin
			len = DAYS_SHORT;
		end else begin
			len = DAYS_LONG;
		end
		return len;
	endfunction

endpackage

>>> hw/rtl/gds_ctrl.sv
// Sequencing state machine and result-valid register for the date stepper.
module gds_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	input  gds_pkg::gds_status_t status,
	output gds_pkg::gds_cmd_t    cmd
);

	gds_pkg::gds_state_t state_q;
	gds_pkg::gds_state_t state_nxt;
	logic                rsp_valid_q;
	logic                out_free;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != gds_pkg::ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			gds_pkg::ST_IDLE: begin
				if (req_valid) state_nxt = gds_pkg::ST_DIV;
			end
			gds_pkg::ST_DIV: begin
				state_nxt = status.year_bad ? gds_pkg::ST_DONE : gds_pkg::ST_REM;
			end
			gds_pkg::ST_REM: begin
				state_nxt = gds_pkg::ST_CLAMP;
			end
			gds_pkg::ST_CLAMP: begin
				state_nxt = gds_pkg::ST_STEP;
			end
			gds_pkg::ST_STEP: begin
				if (status.cnt_zero || status.bound) state_nxt = gds_pkg::ST_DONE;
			end
			gds_pkg::ST_DONE: begin
				if (out_free) state_nxt = gds_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = gds_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			gds_pkg::ST_IDLE:  cmd.load  = req_valid;
			gds_pkg::ST_DIV:   cmd.div   = 1'b1;
			gds_pkg::ST_REM:   cmd.rem   = 1'b1;
			gds_pkg::ST_CLAMP: cmd.clamp = 1'b1;
			gds_pkg::ST_STEP:  cmd.step  = !status.cnt_zero;
			gds_pkg::ST_DONE:  cmd.emit  = out_free;
			default:           cmd       = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gds_pkg::ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> hw/rtl/gds_dpath.sv
// Date registers, century tracking, day stepping and result register.
module gds_dpath (
	input  logic                 clk,
	input  gds_pkg::gds_req_t     req,
	input  gds_pkg::gds_cmd_t     cmd,
	output gds_pkg::gds_status_t  status,
	output gds_pkg::gds_rsp_t     rsp
);

	logic        op_q;
	logic [13:0] year_q;
	logic [3:0]  month_q;
	logic [4:0]  day_q;
	logic [15:0] cnt_q;
	logic        err_q;
	logic [6:0]  cent_q;
	logic [6:0]  yrem_q;
	gds_pkg::gds_rsp_t rsp_q;

	logic [26:0] recip_prod;
	logic [13:0] cent_prod;
	logic [13:0] rem_full;
	logic        leap;
	logic [4:0]  len;
	logic [4:0]  prev_len;
	logic [4:0]  day_lo;
	logic        fwd_bound;
	logic        bwd_bound;

	assign recip_prod = 27'(year_q) * 27'(gds_pkg::CENT_RECIP);
	assign cent_prod  = 14'(cent_q) * 14'(gds_pkg::CENTURY);
	assign rem_full   = year_q - cent_prod;

	assign leap = ((year_q[1:0] == 2'd0) && (yrem_q != 7'd0)) ||
	              ((yrem_q == 7'd0) && (cent_q[1:0] == 2'd0));
	assign len      = gds_pkg::month_len(month_q, leap);
	assign prev_len = gds_pkg::month_len(month_q - 4'd1, leap);
	assign day_lo   = (day_q == 5'd0) ? gds_pkg::FIRST_DAY : day_q;

	assign fwd_bound = (day_q >= len) && (month_q == gds_pkg::LAST_MONTH) &&
	                   (year_q >= gds_pkg::YEAR_MAX);
	assign bwd_bound = (day_q <= gds_pkg::FIRST_DAY) && (month_q == gds_pkg::MONTH_JAN) &&
	                   (year_q == 14'd0);

	assign status.year_bad = (year_q > gds_pkg::YEAR_MAX);
	assign status.cnt_zero = (cnt_q == 16'd0);
	assign status.bound    = (cnt_q != 16'd0) && (op_q ? bwd_bound : fwd_bound);

	assign rsp = rsp_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= req.operation;
			year_q  <= req.start_year;
			month_q <= req.start_month;
			day_q   <= req.start_day;
			cnt_q   <= req.day_count;
			err_q   <= 1'b0;
		end
		if (cmd.div) begin
			cent_q <= recip_prod[gds_pkg::CENT_SHIFT +: 7];
			if (status.year_bad) begin
				err_q <= 1'b1;
			end else if (month_q > gds_pkg::LAST_MONTH) begin
				month_q <= gds_pkg::LAST_MONTH;
			end
		end
		if (cmd.rem) begin
			yrem_q <= rem_full[6:0];
		end
		if (cmd.clamp) begin
			day_q <= (day_lo > len) ? len : day_lo;
		end
		if (cmd.step) begin
			cnt_q <= cnt_q - 16'd1;
			if (status.bound) begin
				err_q <= 1'b1;
			end else if (!op_q) begin
				if (day_q < len) begin
					day_q <= day_q + 5'd1;
				end else if (month_q == gds_pkg::LAST_MONTH) begin
					year_q  <= year_q + 14'd1;
					month_q <= gds_pkg::MONTH_JAN;
					day_q   <= gds_pkg::FIRST_DAY;
					if (yrem_q == gds_pkg::LAST_REM) begin
						yrem_q <= 7'd0;
						cent_q <= cent_q + 7'd1;
					end else begin
						yrem_q <= yrem_q + 7'd1;
					end
				end else begin
					month_q <= month_q + 4'd1;
					day_q   <= gds_pkg::FIRST_DAY;
				end
			end else begin
				if (day_q > gds_pkg::FIRST_DAY) begin
					day_q <= day_q - 5'd1;
				end else if (month_q == gds_pkg::MONTH_JAN) begin
					year_q  <= year_q - 14'd1;
					month_q <= gds_pkg::LAST_MONTH;
					day_q   <= gds_pkg::DAYS_LONG;
					if (yrem_q == 7'd0) begin
						yrem_q <= gds_pkg::LAST_REM;
						cent_q <= cent_q - 7'd1;
					end else begin
						yrem_q <= yrem_q - 7'd1;
					end
				end else begin
					month_q <= month_q - 4'd1;
					day_q   <= prev_len;
				end
			end
		end
		if (cmd.emit) begin
			rsp_q.result_year  <= year_q;
			rsp_q.result_month <= month_q;
			rsp_q.result_day   <= day_q;
			rsp_q.range_error  <= err_q;
		end
	end

endmodule

>>> hw/rtl/gregorian_date_day_stepper.sv
// Top level of the Gregorian date day stepper: controller plus datapath.
//
//   channel   signals                         payload
//   request   req_valid / req_stall / req     operation, start date, day count
//   result    rsp_valid / rsp_stall / rsp     result date, range error
//
// The step loop moves the date one day per cycle until the day count is used
// up or a range bound is hit; a start year above 9999 skips the rest of setup and the loop.
// Setup states DIV, REM and CLAMP split the year into century and remainder and clamp the date.
// One request is worked at a time; the next is taken once the result is
// registered, even while that result is still stalled.
// Reset is asynchronous and empties the controller and result-valid register.
module gregorian_date_day_stepper (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  gds_pkg::gds_req_t  req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output gds_pkg::gds_rsp_t  rsp
);

	gds_pkg::gds_cmd_t    cmd;
	gds_pkg::gds_status_t status;

	gds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.cmd       (cmd)
	);

	gds_dpath u_dpath (
		.clk    (clk),
		.req    (req),
		.cmd    (cmd),
		.status (status),
		.rsp    (rsp)
	);

endmodule

>>> sim/tb.sv
// Self-checking testbench for the Gregorian date day stepper: queued requests, predicted dates.
`timescale 1ns / 1ps

module tb;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_SUB = 1'b1;
	localparam int   DRAIN_CYCLES = 16;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	gds_pkg::gds_req_t  req = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	gds_pkg::gds_rsp_t  rsp;

	gds_pkg::gds_req_t  date_requests[$];
	gds_pkg::gds_rsp_t  expected_dates[$];
	gds_pkg::gds_rsp_t  want;
	logic               req_taken = 1'b0;
	int                 send_idle_pct = 0;
	int                 rsp_stall_pct = 0;
	int                 date_mismatches = 0;

	gregorian_date_day_stepper u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	function automatic logic [4:0] month_days(input logic [3:0] mon, input logic [13:0] yr);
		logic is_leap;
		is_leap = ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
		case (mon)
			gds_pkg::MONTH_FEB: return is_leap ? gds_pkg::DAYS_FEB_LP : gds_pkg::DAYS_FEB;
			gds_pkg::MONTH_APR, gds_pkg::MONTH_JUN,
			gds_pkg::MONTH_SEP, gds_pkg::MONTH_NOV: return gds_pkg::DAYS_SHORT;
			default: return gds_pkg::DAYS_LONG;
		endcase
	endfunction

	function automatic gds_pkg::gds_rsp_t step_date(input gds_pkg::gds_req_t r);
		gds_pkg::gds_rsp_t res;
		logic [13:0] yr;
		logic [3:0]  mon;
		logic [4:0]  dy;
		logic        bad;
		int unsigned n;
		yr = r.start_year;
		mon = r.start_month;
		dy = r.start_day;
		bad = 1'b0;
		if (yr > gds_pkg::YEAR_MAX) begin
			bad = 1'b1;
		end else begin
			if (mon > gds_pkg::LAST_MONTH)
				mon = gds_pkg::LAST_MONTH;
			if (dy < gds_pkg::FIRST_DAY)
				dy = gds_pkg::FIRST_DAY;
			if (dy > month_days(mon, yr))
				dy = month_days(mon, yr);
			for (n = 0; n < r.day_count && !bad; n++) begin
				if (r.operation == OP_ADD) begin
					if (dy < month_days(mon, yr)) begin
						dy++;
					end else if (mon == gds_pkg::LAST_MONTH) begin
						if (yr >= gds_pkg::YEAR_MAX) begin
							bad = 1'b1;
						end else begin
							yr++;
							mon = gds_pkg::MONTH_JAN;
							dy = gds_pkg::FIRST_DAY;
						end
					end else begin
						mon++;
						dy = gds_pkg::FIRST_DAY;
					end
				end else begin
					if (dy > gds_pkg::FIRST_DAY) begin
						dy--;
					end else if (mon == gds_pkg::MONTH_JAN) begin
						if (yr == 0) begin
							bad = 1'b1;
						end else begin
							yr--;
							mon = gds_pkg::LAST_MONTH;
							dy = gds_pkg::DAYS_LONG;
						end
					end else begin
						mon--;
						dy = month_days(mon, yr);
					end
				end
			end
		end
		res.result_year = yr;
		res.result_month = mon;
		res.result_day = dy;
		res.range_error = bad;
		return res;
	endfunction

	task automatic queue_date(input logic op, input logic [13:0] yr, input logic [3:0] mon,
			input logic [4:0] dy, input logic [15:0] n);
		gds_pkg::gds_req_t r;
		r.operation = op;
		r.start_year = yr;
		r.start_month = mon;
		r.start_day = dy;
		r.day_count = n;
		date_requests.push_back(r);
	endtask

	always @(posedge clk) begin
		req_taken <= req_valid && !req_stall;
		if (req_valid && !req_stall)
			expected_dates.push_back(step_date(req));
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_taken) begin
			if (date_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				req_valid <= 1'b1;
				req <= date_requests.pop_front();
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
	end

	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall) begin
			if (expected_dates.size() == 0) begin
				date_mismatches++;
				if (date_mismatches <= 10)
					$display("unexpected result: %0d/%0d/%0d range_error %0b",
						rsp.result_year, rsp.result_month, rsp.result_day,
						rsp.range_error);
			end else begin
				want = expected_dates.pop_front();
				if (rsp.result_year !== want.result_year
						|| rsp.result_month !== want.result_month
						|| rsp.result_day !== want.result_day
						|| rsp.range_error !== want.range_error) begin
					date_mismatches++;
					if (date_mismatches <= 10)
						$display("mismatch: want %0d/%0d/%0d err %0b, got %0d/%0d/%0d err %0b",
							want.result_year, want.result_month, want.result_day,
							want.range_error, rsp.result_year, rsp.result_month,
							rsp.result_day, rsp.range_error);
				end
			end
		end
	end

	initial begin
		int          phase;
		int          i;
		int          k;
		logic [13:0] yr;
		logic [15:0] n;
		logic        op_r;
		logic [3:0]  mon_r;
		logic [4:0]  dy_r;

		queue_date(OP_ADD, 14'd2024, gds_pkg::MONTH_JAN, 5'd15, 16'd0);
		queue_date(OP_ADD, 14'd2023, gds_pkg::MONTH_JAN, 5'd31, 16'd1);
		queue_date(OP_ADD, 14'd2024, gds_pkg::MONTH_FEB, 5'd28, 16'd1);
		queue_date(OP_ADD, 14'd2023, gds_pkg::MONTH_FEB, 5'd28, 16'd1);
		queue_date(OP_ADD, 14'd1900, gds_pkg::MONTH_FEB, 5'd28, 16'd1);
		queue_date(OP_ADD, 14'd2000, gds_pkg::MONTH_FEB, 5'd28, 16'd1);
		queue_date(OP_ADD, 14'd2023, gds_pkg::LAST_MONTH, 5'd31, 16'd1);
		queue_date(OP_SUB, 14'd2024, gds_pkg::MONTH_JAN, 5'd1, 16'd1);
		queue_date(OP_SUB, 14'd2024, 4'd2, 5'd1, 16'd1);
		queue_date(OP_SUB, 14'd2100, 4'd2, 5'd1, 16'd1);
		queue_date(OP_SUB, 14'd2023, 4'd4, 5'd1, 16'd1);
		queue_date(OP_ADD, gds_pkg::YEAR_MAX, gds_pkg::LAST_MONTH, 5'd31, 16'd1);
		queue_date(OP_ADD, 14'd9990, gds_pkg::MONTH_JAN, 5'd1, 16'hFFFF);
		queue_date(OP_SUB, 14'd0, gds_pkg::MONTH_JAN, 5'd1, 16'd1);
		queue_date(OP_SUB, 14'd100, gds_pkg::MONTH_JUN, 5'd15, 16'hFFFF);
		queue_date(OP_ADD, 14'd10000, 4'd15, 5'd31, 16'd5);
		queue_date(OP_SUB, 14'h3FFF, 4'd15, 5'd0, 16'hFFFF);
		queue_date(OP_ADD, 14'd2023, 4'd12, 5'd31, 16'd0);
		queue_date(OP_ADD, 14'd2023, 4'd15, 5'd0, 16'd1);
		queue_date(OP_SUB, 14'd2023, 4'd2, 5'd0, 16'd1);
		queue_date(OP_ADD, 14'd2023, gds_pkg::MONTH_APR, 5'd31, 16'd1);
		queue_date(OP_ADD, 14'd2024, gds_pkg::MONTH_FEB, 5'd30, 16'd0);
		queue_date(OP_ADD, 14'd0, gds_pkg::MONTH_JAN, 5'd1, 16'hFFFF);
		queue_date(OP_SUB, gds_pkg::YEAR_MAX, gds_pkg::LAST_MONTH, 5'd31, 16'hFFFF);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (phase = 0; phase < 4; phase++) begin
			@(posedge clk);
			case (phase)
				0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
				1: begin send_idle_pct = 62; rsp_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  rsp_stall_pct = 62; end
				default: begin send_idle_pct = 29; rsp_stall_pct = 29; end
			endcase
			for (i = 0; i < 19; i++) begin
				k = $urandom_range(9);
				case (k)
					0: yr = 14'($urandom_range(2));
					1: yr = 14'($urandom_range(9999, 9997));
					2: yr = 14'($urandom_range(16383, 10000));
					3: yr = 14'($urandom_range(99) * 100);
					default: yr = 14'($urandom_range(9999));
				endcase
				k = $urandom_range(99);
				if (k < 80)
					n = 16'($urandom_range(400));
				else if (k < 95)
					n = 16'($urandom_range(5000));
				else
					n = 16'($urandom_range(65535));
				op_r = 1'($urandom_range(1));
				if ($urandom_range(9) == 0)
					mon_r = 4'($urandom_range(15, 12));
				else
					mon_r = 4'($urandom_range(11));
				dy_r = 5'($urandom_range(31));
				queue_date(op_r, yr, mon_r, dy_r, n);
			end
			while (date_requests.size() != 0 || req_valid || expected_dates.size() != 0)
				@(negedge clk);
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (date_mismatches == 0 && expected_dates.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#400_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/gds_pkg.sv
hw/rtl/gds_ctrl.sv
hw/rtl/gds_dpath.sv
hw/rtl/gregorian_date_day_stepper.sv
sim/tb.sv
